/* hw/rtl/clm_pkg.sv */
// Shared types, codes and constants for the copy/literal map decoder.
`default_nettype none

package clm_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_COUNT   = 3'd2,
        PH_HASH    = 3'd3,
        PH_CMD     = 3'd4,
        PH_COPY    = 3'd5,
        PH_LIT     = 3'd6
    } t_phase;

    // Result kinds
    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_COPY    = 3'd1;
    localparam logic [2:0] KIND_HASH    = 3'd2;
    localparam logic [2:0] KIND_FINISH  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_MAGIC        = 4'd1;
    localparam logic [3:0] ERR_VERSION      = 4'd2;
    localparam logic [3:0] ERR_COUNT        = 4'd3;
    localparam logic [3:0] ERR_SHORT_HEADER = 4'd4;
    localparam logic [3:0] ERR_MISSING_HASH = 4'd5;
    localparam logic [3:0] ERR_BAD_INDEX    = 4'd6;
    localparam logic [3:0] ERR_ZERO_LENGTH  = 4'd7;
    localparam logic [3:0] ERR_ZERO_LITERAL = 4'd8;
    localparam logic [3:0] ERR_SHORT_LIT    = 4'd9;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIERS_GIVEN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_OPEN     = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output beat widths
    localparam int unsigned OUT_FIELDS_W = 81;
    localparam int unsigned OUT_TDATA_W  = 88;

    // One result item
    typedef struct packed {
        logic        last;
        logic [3:0]  err;
        logic [4:0]  pos;
        logic [15:0] len;
        logic [31:0] off;
        logic [15:0] idx;
        logic [7:0]  data;
        logic [2:0]  kind;
    } t_result;

    // Results produced by one accepted input beat, in order
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Header magic text
    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'h4C;
            3'd1:    b = 8'h49;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h45;
            3'd4:    b = 8'h43;
            3'd5:    b = 8'h4D;
            3'd6:    b = 8'h41;
            default: b = 8'h50;
        endcase
        return b;
    endfunction

    // Carriers at index 16 and above are never open
    function automatic logic carrier_open(input logic [15:0] idx, input logic [15:0] mask);
        return (idx[15:4] == 12'd0) && mask[idx[3:0]];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/clm_parser.sv */
// Map byte parser: header checks, hash bytes, copy and literal records.
`default_nettype none

module clm_parser #(
    parameter int unsigned MAX_SOURCES  = 16,
    parameter int unsigned DIGEST_BYTES = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_end,
    input  wire logic [15:0]            i_expected_version,
    input  wire logic [4:0]             i_carriers_given,
    input  wire logic [15:0]            i_carrier_open_mask,
    output clm_pkg::t_push              o_push
);

    localparam int unsigned BC_W  = $clog2(DIGEST_BYTES + 1);
    localparam int unsigned CNT_W = $clog2(MAX_SOURCES + 1);

    clm_pkg::t_phase    r_phase,   n_phase;
    logic [BC_W-1:0]    r_bc,      n_bc;
    logic [7:0]         r_acc,     n_acc;
    logic [15:0]        r_idx,     n_idx;
    logic [31:0]        r_off,     n_off;
    logic [6:0]         r_lr,      n_lr;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [CNT_W-1:0]   r_cc,      n_cc;
    logic               r_seen,    n_seen;
    logic               r_stopped, n_stopped;
    logic [3:0]         r_stop,    n_stop;

    logic               first_vld;
    clm_pkg::t_result   first_res;
    logic               second_vld;
    clm_pkg::t_result   second_res;
    logic [3:0]         err;
    logic [3:0]         fin;
    logic [15:0]        field;
    logic [15:0]        copy_len;
    logic               seen_new;
    logic [CNT_W-1:0]   cc_inc;
    clm_pkg::t_push     push;

    // Work out next state and the results of the current beat
    always_comb begin
        n_phase    = r_phase;
        n_bc       = r_bc;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_off      = r_off;
        n_lr       = r_lr;
        n_count    = r_count;
        n_cc       = r_cc;
        n_seen     = r_seen;
        n_stopped  = r_stopped;
        n_stop     = r_stop;
        err        = clm_pkg::ERR_NONE;
        fin        = clm_pkg::ERR_NONE;
        first_vld  = 1'b0;
        first_res  = '0;
        second_vld = 1'b0;
        second_res = '0;
        field      = {i_byte, r_acc};
        copy_len   = {i_byte, r_acc};
        seen_new   = r_seen | (i_byte != 8'd0);
        cc_inc     = r_cc + CNT_W'(1);

        if (!r_stopped) begin
            unique case (r_phase)
                clm_pkg::PH_MAGIC: begin
                    if (i_byte != clm_pkg::magic_byte(r_bc[2:0])) begin
                        err = clm_pkg::ERR_MAGIC;
                    end else if (r_bc == BC_W'(7)) begin
                        n_phase = clm_pkg::PH_VERSION;
                        n_bc    = '0;
                    end else begin
                        n_bc = r_bc + BC_W'(1);
                    end
                end
                clm_pkg::PH_VERSION, clm_pkg::PH_COUNT: begin
                    if (r_bc == '0) begin
                        n_acc = i_byte;
                        n_bc  = BC_W'(1);
                    end else begin
                        n_bc = '0;
                        if (r_phase == clm_pkg::PH_VERSION) begin
                            if (field != i_expected_version) begin
                                err = clm_pkg::ERR_VERSION;
                            end else begin
                                n_phase = clm_pkg::PH_COUNT;
                            end
                        end else if (field != {11'd0, i_carriers_given} ||
                                     field > 16'(MAX_SOURCES)) begin
                            err = clm_pkg::ERR_COUNT;
                        end else begin
                            n_count = field[CNT_W-1:0];
                            n_cc    = '0;
                            n_seen  = 1'b0;
                            n_phase = (field == 16'd0) ? clm_pkg::PH_CMD : clm_pkg::PH_HASH;
                        end
                    end
                end
                clm_pkg::PH_HASH: begin
                    first_vld      = 1'b1;
                    first_res.kind = clm_pkg::KIND_HASH;
                    first_res.data = i_byte;
                    first_res.idx  = 16'(r_cc);
                    first_res.pos  = r_bc[4:0];
                    if (r_bc == BC_W'(DIGEST_BYTES - 1)) begin
                        if (!clm_pkg::carrier_open(16'(r_cc), i_carrier_open_mask) &&
                            seen_new) begin
                            err = clm_pkg::ERR_MISSING_HASH;
                        end else begin
                            n_cc   = cc_inc;
                            n_bc   = '0;
                            n_seen = 1'b0;
                            if (cc_inc >= r_count) begin
                                n_phase = clm_pkg::PH_CMD;
                            end
                        end
                    end else begin
                        n_bc   = r_bc + BC_W'(1);
                        n_seen = seen_new;
                    end
                end
                clm_pkg::PH_CMD: begin
                    if (i_byte[7]) begin
                        n_phase = clm_pkg::PH_COPY;
                        n_bc    = '0;
                    end else if (i_byte == 8'd0) begin
                        err = clm_pkg::ERR_ZERO_LITERAL;
                    end else begin
                        n_lr    = i_byte[6:0];
                        n_phase = clm_pkg::PH_LIT;
                    end
                end
                clm_pkg::PH_COPY: begin
                    // Record bytes: index, offset, length, all little-endian
                    n_bc = r_bc + BC_W'(1);
                    case (r_bc[2:0])
                        3'd0: n_idx[7:0]   = i_byte;
                        3'd1: n_idx[15:8]  = i_byte;
                        3'd2: n_off[7:0]   = i_byte;
                        3'd3: n_off[15:8]  = i_byte;
                        3'd4: n_off[23:16] = i_byte;
                        3'd5: n_off[31:24] = i_byte;
                        3'd6: n_acc        = i_byte;
                        default: begin
                            n_phase = clm_pkg::PH_CMD;
                            n_bc    = '0;
                            if (r_idx >= 16'(r_count) ||
                                !clm_pkg::carrier_open(r_idx, i_carrier_open_mask)) begin
                                err = clm_pkg::ERR_BAD_INDEX;
                            end else if (copy_len == 16'd0) begin
                                err = clm_pkg::ERR_ZERO_LENGTH;
                            end else begin
                                first_vld      = 1'b1;
                                first_res.kind = clm_pkg::KIND_COPY;
                                first_res.idx  = r_idx;
                                first_res.off  = r_off;
                                first_res.len  = copy_len;
                            end
                        end
                    endcase
                end
                clm_pkg::PH_LIT: begin
                    first_vld      = 1'b1;
                    first_res.kind = clm_pkg::KIND_LITERAL;
                    first_res.data = i_byte;
                    n_lr           = r_lr - 7'd1;
                    if (r_lr <= 7'd1) begin
                        n_phase = clm_pkg::PH_CMD;
                    end
                end
                default: begin
                    n_phase = clm_pkg::PH_MAGIC;
                end
            endcase
        end

        // Error or end-of-map result
        if (err != clm_pkg::ERR_NONE) begin
            second_vld      = 1'b1;
            second_res.kind = clm_pkg::KIND_ERROR;
            second_res.err  = err;
            second_res.last = i_end;
            n_stopped       = 1'b1;
            n_stop          = err;
        end else if (i_end) begin
            if (r_stopped) begin
                fin = r_stop;
            end else begin
                case (n_phase)
                    clm_pkg::PH_MAGIC:   fin = clm_pkg::ERR_MAGIC;
                    clm_pkg::PH_VERSION,
                    clm_pkg::PH_COUNT,
                    clm_pkg::PH_HASH:    fin = clm_pkg::ERR_SHORT_HEADER;
                    clm_pkg::PH_LIT:     fin = clm_pkg::ERR_SHORT_LIT;
                    default:             fin = clm_pkg::ERR_NONE;
                endcase
            end
            second_vld      = 1'b1;
            second_res.kind = (fin != clm_pkg::ERR_NONE) ? clm_pkg::KIND_ERROR
                                                         : clm_pkg::KIND_FINISH;
            second_res.err  = fin;
            second_res.last = 1'b1;
        end

        // Drop all parser state at the end of a map
        if (i_end) begin
            n_phase   = clm_pkg::PH_MAGIC;
            n_bc      = '0;
            n_lr      = '0;
            n_count   = '0;
            n_cc      = '0;
            n_seen    = 1'b0;
            n_stopped = 1'b0;
            n_stop    = clm_pkg::ERR_NONE;
        end

        // Order the results of this beat
        push.n  = {1'b0, first_vld} + {1'b0, second_vld};
        push.r0 = first_vld ? first_res : second_res;
        push.r1 = second_res;
        if (!i_accept) begin
            push.n = 2'd0;
        end
    end

    assign o_push = push;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= clm_pkg::PH_MAGIC;
            r_bc      <= '0;
            r_lr      <= '0;
            r_count   <= '0;
            r_cc      <= '0;
            r_seen    <= 1'b0;
            r_stopped <= 1'b0;
            r_stop    <= clm_pkg::ERR_NONE;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_bc      <= n_bc;
            r_lr      <= n_lr;
            r_count   <= n_count;
            r_cc      <= n_cc;
            r_seen    <= n_seen;
            r_stopped <= n_stopped;
            r_stop    <= n_stop;
        end
    end

    // Field assembly registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_acc <= n_acc;
            r_idx <= n_idx;
            r_off <= n_off;
        end
    end

`ifndef SYNTHESIS
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_stopped && !i_end) |-> (o_push.n == 2'd0))
        else $error("stopped parser produced a result");
    a_second_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n == 2'd2) |-> (o_push.r1.kind == clm_pkg::KIND_ERROR ||
                                o_push.r1.kind == clm_pkg::KIND_FINISH))
        else $error("second result of a beat is neither error nor finish");
    a_end_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end) |-> (o_push.n != 2'd0))
        else $error("final map byte produced no result");
    a_stopped_holds_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_stop != clm_pkg::ERR_NONE))
        else $error("stopped without an error code");
`endif

endmodule

`default_nettype wire

/* hw/rtl/clm_res_queue.sv */
// Four-entry result queue between the parser and the output stream.
`default_nettype none

module clm_res_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire clm_pkg::t_push   i_push,
    input  wire logic             i_pop,
    output wire logic             o_room,
    output wire logic             o_valid,
    output clm_pkg::t_result      o_head
);

    clm_pkg::t_result                 r_mem [clm_pkg::QUEUE_DEPTH];
    logic [clm_pkg::QPTR_W-1:0]       r_wp;
    logic [clm_pkg::QPTR_W-1:0]       r_rp;
    logic [clm_pkg::QCNT_W-1:0]       r_count;
    logic [clm_pkg::QPTR_W-1:0]       wp_next;
    logic                             pop;

    assign pop     = i_pop && (r_count != '0);
    assign wp_next = r_wp + clm_pkg::QPTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= clm_pkg::QCNT_W'(clm_pkg::QUEUE_DEPTH - 2));
    assign o_head  = r_mem[r_rp];

    // Store up to two results per beat
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp_next] <= i_push.r1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + clm_pkg::QPTR_W'(i_push.n);
            r_rp    <= r_rp + clm_pkg::QPTR_W'(pop);
            r_count <= r_count + clm_pkg::QCNT_W'(i_push.n) - clm_pkg::QCNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> o_room)
        else $error("result queue written without room");
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_count == $past(r_count) + clm_pkg::QCNT_W'($past(i_push.n))
                                - clm_pkg::QCNT_W'($past(pop))))
        else $error("result queue occupancy out of step");
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= clm_pkg::QCNT_W'(clm_pkg::QUEUE_DEPTH))
        else $error("result queue occupancy beyond depth");
`endif

endmodule

`default_nettype wire

/* hw/rtl/copy_literal_map_decoder_unit.sv */
// Top level of the copy/literal map decoder: ports, configuration and result queue.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] map_byte; tlast map_end
//  m_axis    out        tuser kind; tdata result fields (see port); tlast run_last
//  cfg       in         i_cfg_we, i_cfg_index, i_cfg_data: register write, no read-back
//
//  One map byte is taken per cycle while the queue has room; its results are written
//  into a four-entry result queue that feeds m_axis.
//  A byte that yields two results (hash, literal or copy plus error/finish) takes two
//  output beats; s_axis tready drops while fewer than two queue slots are free.
//  Reset is synchronous and clears parser control state and queue; registers return
//  to version 2, no carriers given, no carrier open.
`default_nettype none

module copy_literal_map_decoder_unit #(
    parameter int unsigned MAX_SOURCES  = 16,
    parameter int unsigned DIGEST_BYTES = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // map_byte [7:0]
    input  wire logic [7:0]                         i_s_axis_tdata,
    input  wire logic                               i_s_axis_tvalid,
    input  wire logic                               i_s_axis_tlast,
    output wire logic                               o_s_axis_tready,
    // byte_out [7:0], source_index [23:8], copy_offset [55:24], copy_length [71:56],
    // hash_byte_pos [76:72], error_code [80:77], zero [87:81]
    output wire logic [clm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // kind [2:0]
    output wire logic [2:0]                         o_m_axis_tuser,
    output wire logic                               o_m_axis_tvalid,
    output wire logic                               o_m_axis_tlast,
    input  wire logic                               i_m_axis_tready,
    input  wire logic                               i_cfg_we,
    input  wire logic [clm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [clm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [15:0]        r_expected_version;
    logic [4:0]         r_carriers_given;
    logic [15:0]        r_carrier_open_mask;
    logic               accept;
    logic               room;
    clm_pkg::t_push     push;
    clm_pkg::t_result   head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version  <= 16'd2;
            r_carriers_given    <= 5'd0;
            r_carrier_open_mask <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clm_pkg::CFG_EXPECTED_VERSION: r_expected_version  <= i_cfg_data;
                clm_pkg::CFG_CARRIERS_GIVEN:   r_carriers_given    <= i_cfg_data[4:0];
                clm_pkg::CFG_CARRIER_OPEN:     r_carrier_open_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a beat whenever two result slots are free
    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    clm_parser #(
        .MAX_SOURCES  (MAX_SOURCES),
        .DIGEST_BYTES (DIGEST_BYTES)
    ) u_parser (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_byte              (i_s_axis_tdata),
        .i_end               (i_s_axis_tlast),
        .i_expected_version  (r_expected_version),
        .i_carriers_given    (r_carriers_given),
        .i_carrier_open_mask (r_carrier_open_mask),
        .o_push              (push)
    );

    clm_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head)
    );

    // Pack the head result onto the output beat
    assign o_m_axis_tdata = {
        (clm_pkg::OUT_TDATA_W - clm_pkg::OUT_FIELDS_W)'(0),
        head.err, head.pos, head.len, head.off, head.idx, head.data
    };
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

`default_nettype wire

/* tb/sv/tb_copy_literal_map_decoder_unit.sv */
// Self-checking testbench for the copy/literal map decoder: directed table, then random maps.
`default_nettype none

module tb_copy_literal_map_decoder_unit;

    localparam int MAX_CARRIERS    = 16;
    localparam int DIGEST_LEN      = 32;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PAUSE_CYCLES    = 8;
    localparam int END_CYCLES      = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_BEATS     = 90;
    localparam int PHASE_COUNT     = 7;
    localparam logic [63:0] MAGIC_TEXT = "LIDECMAP";

    // One row of the directed table; fixed rows carry their final result typed in
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        logic [2:0] kind;
        logic [3:0] err;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic [7:0]                      i_s_axis_tdata;
    logic                            i_s_axis_tvalid;
    logic                            i_s_axis_tlast;
    logic                            o_s_axis_tready;
    logic [clm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [2:0]                      o_m_axis_tuser;
    logic                            o_m_axis_tvalid;
    logic                            o_m_axis_tlast;
    logic                            i_m_axis_tready;
    logic                            i_cfg_we;
    logic [clm_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [clm_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    // Register mirror
    logic [15:0] cfg_version;
    logic [4:0]  cfg_carriers;
    logic [15:0] cfg_open;

    // Parser mirror
    clm_pkg::t_phase parse_phase;
    logic [5:0]  step_count;
    logic [31:0] field_acc;
    logic [15:0] copy_index;
    logic [31:0] copy_offset_acc;
    logic [6:0]  lit_left;
    logic [15:0] map_count;
    logic [15:0] carrier_at;
    logic        digest_nonzero;
    logic        halted;
    logic [3:0]  halt_code;

    clm_pkg::t_result expected_beats [$];
    logic [7:0]  map_bytes [$];
    t_row        directed_rows [23];
    int          last_step_results;
    int          map_beats;
    int          failures;
    logic        calm;
    logic        hold_off_req;

    copy_literal_map_decoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] magic_letter(input int pos);
        return MAGIC_TEXT[63 - 8 * pos -: 8];
    endfunction

    function automatic logic is_readable(input logic [15:0] carrier);
        return (carrier < 16) && cfg_open[carrier[3:0]];
    endfunction

    // Mostly short gaps, a few long ones, none in a calm stretch
    function automatic int idle_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_parse_state();
        parse_phase     = clm_pkg::PH_MAGIC;
        step_count      = '0;
        field_acc       = '0;
        copy_index      = '0;
        copy_offset_acc = '0;
        lit_left        = '0;
        map_count       = '0;
        carrier_at      = '0;
        digest_nonzero  = 1'b0;
        halted          = 1'b0;
        halt_code       = clm_pkg::ERR_NONE;
    endtask

    task automatic expect_beat(input logic [2:0] kind, input logic [7:0] data,
                               input logic [15:0] idx, input logic [31:0] off,
                               input logic [15:0] len, input logic [4:0] pos,
                               input logic [3:0] err, input logic last);
        clm_pkg::t_result r;
        r.kind = kind;
        r.data = data;
        r.idx  = idx;
        r.off  = off;
        r.len  = len;
        r.pos  = pos;
        r.err  = err;
        r.last = last;
        expected_beats.push_back(r);
        last_step_results++;
    endtask

    // Advance the parser mirror by one map byte and queue what it yields
    task automatic decode_map_byte(input logic [7:0] b, input logic e);
        logic [3:0] fault;
        logic [3:0] closing;
        fault = clm_pkg::ERR_NONE;
        last_step_results = 0;
        if (!halted) begin
            case (parse_phase)
                clm_pkg::PH_MAGIC: begin
                    if (b != magic_letter(step_count[2:0])) begin
                        fault = clm_pkg::ERR_MAGIC;
                    end else if (step_count == 6'd7) begin
                        parse_phase = clm_pkg::PH_VERSION;
                        step_count  = '0;
                        field_acc   = '0;
                    end else begin
                        step_count++;
                    end
                end
                clm_pkg::PH_VERSION, clm_pkg::PH_COUNT: begin
                    field_acc = field_acc | (32'(b) << (8 * step_count[0]));
                    step_count++;
                    if (step_count >= 2) begin
                        step_count = '0;
                        if (parse_phase == clm_pkg::PH_VERSION) begin
                            if (field_acc != 32'(cfg_version)) begin
                                fault = clm_pkg::ERR_VERSION;
                            end else begin
                                parse_phase = clm_pkg::PH_COUNT;
                                field_acc   = '0;
                            end
                        end else if (field_acc != 32'(cfg_carriers) ||
                                     field_acc > MAX_CARRIERS) begin
                            fault = clm_pkg::ERR_COUNT;
                        end else begin
                            map_count      = field_acc[15:0];
                            field_acc      = '0;
                            carrier_at     = '0;
                            digest_nonzero = 1'b0;
                            parse_phase    = (map_count == 0) ? clm_pkg::PH_CMD
                                                              : clm_pkg::PH_HASH;
                        end
                    end
                end
                clm_pkg::PH_HASH: begin
                    expect_beat(clm_pkg::KIND_HASH, b, carrier_at, '0, '0, step_count[4:0],
                                clm_pkg::ERR_NONE, 1'b0);
                    if (b != 8'h00) digest_nonzero = 1'b1;
                    step_count++;
                    if (step_count >= DIGEST_LEN) begin
                        if (!is_readable(carrier_at) && digest_nonzero) begin
                            fault = clm_pkg::ERR_MISSING_HASH;
                        end else begin
                            carrier_at++;
                            step_count     = '0;
                            digest_nonzero = 1'b0;
                            if (carrier_at >= map_count) parse_phase = clm_pkg::PH_CMD;
                        end
                    end
                end
                clm_pkg::PH_CMD: begin
                    if (b[7]) begin
                        parse_phase     = clm_pkg::PH_COPY;
                        step_count      = '0;
                        copy_index      = '0;
                        copy_offset_acc = '0;
                        field_acc       = '0;
                    end else if (b == 8'h00) begin
                        fault = clm_pkg::ERR_ZERO_LITERAL;
                    end else begin
                        lit_left    = b[6:0];
                        parse_phase = clm_pkg::PH_LIT;
                    end
                end
                clm_pkg::PH_COPY: begin
                    if (step_count < 2)
                        copy_index = copy_index | (16'(b) << (8 * step_count));
                    else if (step_count < 6)
                        copy_offset_acc = copy_offset_acc | (32'(b) << (8 * (step_count - 2)));
                    else
                        field_acc = field_acc | (32'(b) << (8 * step_count[0]));
                    step_count++;
                    if (step_count >= 8) begin
                        parse_phase = clm_pkg::PH_CMD;
                        step_count  = '0;
                        if (copy_index >= map_count || !is_readable(copy_index))
                            fault = clm_pkg::ERR_BAD_INDEX;
                        else if (field_acc == 0)
                            fault = clm_pkg::ERR_ZERO_LENGTH;
                        else
                            expect_beat(clm_pkg::KIND_COPY, '0, copy_index, copy_offset_acc,
                                        field_acc[15:0], '0, clm_pkg::ERR_NONE, 1'b0);
                    end
                end
                clm_pkg::PH_LIT: begin
                    expect_beat(clm_pkg::KIND_LITERAL, b, '0, '0, '0, '0,
                                clm_pkg::ERR_NONE, 1'b0);
                    if (lit_left > 0) lit_left--;
                    if (lit_left == 0) parse_phase = clm_pkg::PH_CMD;
                end
                default: begin
                    parse_phase = clm_pkg::PH_MAGIC;
                end
            endcase
        end

        // Report a fresh fault once; the final byte closes the map
        if (fault != clm_pkg::ERR_NONE) begin
            expect_beat(clm_pkg::KIND_ERROR, '0, '0, '0, '0, '0, fault, e);
            halted    = 1'b1;
            halt_code = fault;
        end else if (e) begin
            if (halted) begin
                closing = halt_code;
            end else begin
                case (parse_phase)
                    clm_pkg::PH_MAGIC:   closing = clm_pkg::ERR_MAGIC;
                    clm_pkg::PH_VERSION,
                    clm_pkg::PH_COUNT,
                    clm_pkg::PH_HASH:    closing = clm_pkg::ERR_SHORT_HEADER;
                    clm_pkg::PH_LIT:     closing = clm_pkg::ERR_SHORT_LIT;
                    default:             closing = clm_pkg::ERR_NONE;
                endcase
            end
            if (closing != clm_pkg::ERR_NONE)
                expect_beat(clm_pkg::KIND_ERROR, '0, '0, '0, '0, '0, closing, 1'b1);
            else
                expect_beat(clm_pkg::KIND_FINISH, '0, '0, '0, '0, '0,
                            clm_pkg::ERR_NONE, 1'b1);
        end
        if (e) clear_parse_state();
    endtask

    // Offer one map byte after a random gap and hold it until taken
    task automatic push_map_byte(input logic [7:0] b, input logic e);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= e;
        i_s_axis_tvalid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        map_beats++;
        decode_map_byte(b, e);
    endtask

    task automatic send_map();
        foreach (map_bytes[i]) push_map_byte(map_bytes[i], i == map_bytes.size() - 1);
    endtask

    // Drop valid, let every expected beat arrive, then give the block time to settle
    task automatic drain_and_pause(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [clm_pkg::CFG_INDEX_W-1:0] reg_index,
                                  input logic [15:0] reg_value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= reg_value;
        @(posedge i_clk);
        case (reg_index)
            clm_pkg::CFG_EXPECTED_VERSION: cfg_version  = reg_value;
            clm_pkg::CFG_CARRIERS_GIVEN:   cfg_carriers = reg_value[4:0];
            clm_pkg::CFG_CARRIER_OPEN:     cfg_open     = reg_value;
            default:                       ;
        endcase
    endtask

    task automatic configure(input logic [15:0] version, input logic [15:0] carriers,
                             input logic [15:0] open_mask);
        write_register(clm_pkg::CFG_EXPECTED_VERSION, version);
        write_register(clm_pkg::CFG_CARRIERS_GIVEN, carriers);
        write_register(clm_pkg::CFG_CARRIER_OPEN, open_mask);
        i_cfg_we <= 1'b0;
    endtask

    // Build one map: mostly well formed with random content, some noise and damage
    task automatic build_map();
        logic [15:0] hdr_count;
        logic [15:0] idx;
        logic [31:0] off;
        logic [15:0] len;
        logic        dirty;
        int          roll;
        int          run;
        int          cut;
        map_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) map_bytes.push_back(8'($urandom));
            return;
        end
        for (int i = 0; i < 8; i++) map_bytes.push_back(magic_letter(i));
        map_bytes.push_back(cfg_version[7:0]);
        map_bytes.push_back(cfg_version[15:8]);
        hdr_count = 16'(cfg_carriers);
        roll = $urandom_range(0, 15);
        if (roll == 0) hdr_count = 16'hFFFF;
        else if (roll == 1) hdr_count = 16'($urandom_range(0, 20));
        map_bytes.push_back(hdr_count[7:0]);
        map_bytes.push_back(hdr_count[15:8]);

        // Wide carrier sets stop inside the digests to keep maps short
        if (hdr_count > 4) begin
            repeat ($urandom_range(0, 40)) map_bytes.push_back(8'($urandom));
            return;
        end
        for (int c = 0; c < hdr_count; c++) begin
            dirty = cfg_open[c] || ($urandom_range(0, 5) == 0);
            repeat (DIGEST_LEN) map_bytes.push_back(dirty ? 8'($urandom) : 8'h00);
        end

        // Command stream
        repeat ($urandom_range(1, 6)) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                run = ($urandom_range(0, 30) == 0) ? 127 : $urandom_range(1, 6);
                map_bytes.push_back(8'(run));
                repeat (run) map_bytes.push_back(8'($urandom));
            end else if (roll < 82) begin
                idx = (hdr_count != 0 && $urandom_range(0, 9) != 0) ?
                      16'($urandom_range(0, hdr_count - 1)) : 16'($urandom);
                off = $urandom;
                len = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
                map_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                map_bytes.push_back(idx[7:0]);
                map_bytes.push_back(idx[15:8]);
                for (int k = 0; k < 4; k++) map_bytes.push_back(off[8 * k +: 8]);
                map_bytes.push_back(len[7:0]);
                map_bytes.push_back(len[15:8]);
            end else if (roll < 88) begin
                map_bytes.push_back(8'h00);
            end else begin
                // Leave a record dangling at the end of the map
                if ($urandom_range(0, 1) == 0) begin
                    run = $urandom_range(2, 10);
                    map_bytes.push_back(8'(run));
                    repeat ($urandom_range(0, run - 1)) map_bytes.push_back(8'($urandom));
                end else begin
                    map_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                    repeat ($urandom_range(0, 7)) map_bytes.push_back(8'($urandom));
                end
                break;
            end
        end

        // Damage a byte or cut the map short now and then
        if ($urandom_range(0, 9) == 0)
            map_bytes[$urandom_range(0, map_bytes.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, map_bytes.size());
            map_bytes = map_bytes[0:cut-1];
        end
    endtask

    // Compare one result beat with the oldest expectation
    task automatic check_result_beat();
        clm_pkg::t_result seen;
        clm_pkg::t_result want;
        seen.kind = o_m_axis_tuser;
        seen.data = o_m_axis_tdata[7:0];
        seen.idx  = o_m_axis_tdata[23:8];
        seen.off  = o_m_axis_tdata[55:24];
        seen.len  = o_m_axis_tdata[71:56];
        seen.pos  = o_m_axis_tdata[76:72];
        seen.err  = o_m_axis_tdata[80:77];
        seen.last = o_m_axis_tlast;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: kind %0d", seen.kind);
            failures++;
            return;
        end
        want = expected_beats.pop_front();
        if (seen.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, seen.kind);
            failures++;
        end
        if (seen.data !== want.data) begin
            $error("byte_out: expected %0h, got %0h", want.data, seen.data);
            failures++;
        end
        if (seen.idx !== want.idx) begin
            $error("source_index: expected %0d, got %0d", want.idx, seen.idx);
            failures++;
        end
        if (seen.off !== want.off) begin
            $error("copy_offset: expected %0h, got %0h", want.off, seen.off);
            failures++;
        end
        if (seen.len !== want.len) begin
            $error("copy_length: expected %0d, got %0d", want.len, seen.len);
            failures++;
        end
        if (seen.pos !== want.pos) begin
            $error("hash_byte_pos: expected %0d, got %0d", want.pos, seen.pos);
            failures++;
        end
        if (seen.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, seen.err);
            failures++;
        end
        if (seen.last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, seen.last);
            failures++;
        end
    endtask

    // Result side: check beats, stall at random, hold off for a long stretch on request
    initial begin
        int stall;
        stall = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) check_result_beat();
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else if (stall == 0) begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Give up when no beat moves on either side for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int phase_start;
        int beats_left;
        clm_pkg::t_result typed;
        failures        = 0;
        map_beats       = 0;
        calm            = 1'b0;
        hold_off_req    = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        cfg_version     = 16'd2;
        cfg_carriers    = '0;
        cfg_open        = '0;
        clear_parse_state();

        // Reset values: version 2, no carriers, none open
        directed_rows = '{
            // magic mismatch on the third byte, then the closing byte repeats it
            '{8'h4C, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h49, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'hFF, 1'b0, 1'b1, clm_pkg::KIND_ERROR,   clm_pkg::ERR_MAGIC},
            '{8'h00, 1'b1, 1'b1, clm_pkg::KIND_ERROR,   clm_pkg::ERR_MAGIC},
            // map that ends inside the magic
            '{8'h4C, 1'b1, 1'b1, clm_pkg::KIND_ERROR,   clm_pkg::ERR_MAGIC},
            // full header, no carriers
            '{8'h4C, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h49, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h44, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h45, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h43, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h4D, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h41, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h50, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h02, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            // literal run of two extreme bytes
            '{8'h02, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            // copy record with all low control bits set, cut off after its index
            '{8'hFF, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b0, clm_pkg::KIND_LITERAL, clm_pkg::ERR_NONE},
            '{8'h00, 1'b1, 1'b1, clm_pkg::KIND_FINISH,  clm_pkg::ERR_NONE}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (directed_rows[i]) begin
            push_map_byte(directed_rows[i].data, directed_rows[i].last);
            if (directed_rows[i].fixed) begin
                if (last_step_results > 0) void'(expected_beats.pop_back());
                typed      = '0;
                typed.kind = directed_rows[i].kind;
                typed.err  = directed_rows[i].err;
                typed.last = directed_rows[i].last;
                expected_beats.push_back(typed);
            end
        end

        // Random maps under a run of register settings
        for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
            drain_and_pause(PAUSE_CYCLES);
            case (phase_no)
                0: configure(16'h0000, 16'd0, 16'h0000);
                1: configure(16'hFFFF, 16'd16, 16'hFFFF);
                2: configure(16'($urandom), 16'($urandom_range(1, 3)), 16'($urandom));
                3: configure(16'd2, 16'd2, 16'hFFFF);
                4: configure(16'($urandom), 16'($urandom_range(17, 31)), 16'($urandom));
                5: configure(16'($urandom), 16'($urandom_range(0, 4)), 16'($urandom));
                default: configure(16'd1, 16'd1, 16'h0001);
            endcase
            if (phase_no == 3) hold_off_req = 1'b1;
            phase_start = map_beats;
            while (map_beats - phase_start < PHASE_BEATS) begin
                calm = ($urandom_range(0, 3) == 0);
                build_map();
                // Trim the map to what is left of this phase's budget
                beats_left = PHASE_BEATS - (map_beats - phase_start);
                if (map_bytes.size() > beats_left)
                    map_bytes = map_bytes[0:beats_left-1];
                send_map();
            end
        end

        drain_and_pause(END_CYCLES);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/clm_pkg.sv
hw/rtl/clm_parser.sv
hw/rtl/clm_res_queue.sv
hw/rtl/copy_literal_map_decoder_unit.sv
tb/sv/tb_copy_literal_map_decoder_unit.sv
